// ===== rtl/core/pltd_pkg.sv =====
package pltd_pkg;

	// Width of the limit on the request and of the prime on each result.
	localparam int VAL_W = 8;

	// Upper bound on the results of one request.
	localparam int MAX_RESULTS = 54;

	// Bits needed to count the steps of one bit-serial remainder.
	localparam int STEP_W = $clog2(VAL_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_LOAD,
		ST_DIV,
		ST_STORE,
		ST_NEXT,
		ST_FLUSH,
		ST_EMPTY
	} state_t;

endpackage

// ===== rtl/core/pltd_job_if.sv =====
interface pltd_job_if import pltd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

// ===== rtl/core/pltd_result_if.sv =====
interface pltd_result_if import pltd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] prime;
	logic             last;
	logic             none_found;

	modport source (output valid, output prime, output last, output none_found, input ready);
	modport sink (input valid, input prime, input last, input none_found, output ready);
endinterface

// ===== rtl/core/pltd_ram.sv =====
module pltd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/prime_list_trial_division.sv =====
// One request at a time; a request for limit L costs, for every candidate, one trial
// division per stored prime tried (one table read, one load, eight remainder steps), and
// the bit-serial remainder unit dominates the work. A limit below two is answered with an
// empty result; for larger limits the first result is 2, and each prime is held back until
// the next one is found or the search ends.
// Reset (arst_n low, asynchronous) idles the controller and empties the output register.
module prime_list_trial_division import pltd_pkg::*; #(
	parameter int TABLE_DEPTH  = 64,
	parameter int NUMBER_WIDTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	pltd_job_if.sink        job,
	pltd_result_if.source   result
);

	// Address width of the prime table and the number of primes that may be kept.
	localparam int AW        = $clog2(TABLE_DEPTH);
	localparam int LIMIT_CNT = (TABLE_DEPTH < MAX_RESULTS) ? TABLE_DEPTH : MAX_RESULTS;
	localparam int CW        = $clog2(LIMIT_CNT + 1);
	// Common width for comparing the shifted remainder against a stored prime.
	localparam int DW        = (NUMBER_WIDTH > VAL_W + 1) ? NUMBER_WIDTH : VAL_W + 1;
	// Only the low NUMBER_WIDTH bits of the limit take part.
	localparam logic [VAL_W-1:0] LIMIT_MASK =
		(NUMBER_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((1 << NUMBER_WIDTH) - 1);

	state_t state_q, state_d;

	// Request and candidate bookkeeping.
	logic [VAL_W-1:0] limit_q;
	logic [VAL_W-1:0] cand_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;

	// Remainder unit: one restoring step per cycle.
	logic [NUMBER_WIDTH-1:0] div_q;
	logic [VAL_W-1:0]        rem_q;
	logic [VAL_W-1:0]        dvd_q;
	logic [STEP_W-1:0]       step_q;

	// The newest prime is held back until we know whether it is the last one.
	logic             pend_valid_q;
	logic [VAL_W-1:0] pend_q;

	// Output register, so the search goes on while a result waits to be taken.
	logic             out_valid_q;
	logic [VAL_W-1:0] out_prime_q;
	logic             out_last_q;
	logic             out_none_q;

	logic [VAL_W-1:0]        limit_eff;
	logic [VAL_W:0]          rem_shift;
	logic [DW-1:0]           rem_diff;
	logic                    rem_ge;
	logic [VAL_W-1:0]        rem_next;
	logic                    last_step;
	logic                    rem_zero;
	logic                    out_free;
	logic                    done;
	logic [NUMBER_WIDTH-1:0] rd_data;

	// Control strobes from the output decode.
	logic start;
	logic rd_en;
	logic load_div;
	logic div_step;
	logic idx_inc;
	logic store;
	logic push_pend;
	logic next_cand;
	logic push_final;
	logic push_empty;

	assign limit_eff = job.limit & LIMIT_MASK;
	assign out_free  = !out_valid_q || result.ready;
	assign done      = (cand_q == limit_q) || (cnt_q >= CW'(LIMIT_CNT));

	// One restoring step: shift in the next dividend bit and subtract when it fits.
	assign rem_shift = {rem_q, dvd_q[VAL_W-1]};
	assign rem_ge    = DW'(rem_shift) >= DW'(div_q);
	assign rem_diff  = DW'(rem_shift) - DW'(div_q);
	assign rem_next  = VAL_W'(rem_ge ? rem_diff : DW'(rem_shift));
	assign last_step = step_q == STEP_W'(VAL_W - 1);
	assign rem_zero  = rem_next == '0;

	// The table is written only at entry cnt_q and read only below it, so a read
	// never meets a pending write to the same entry and no forwarding is needed.
	pltd_ram #(
		.WIDTH (NUMBER_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (store),
		.wr_addr (AW'(cnt_q)),
		.wr_data (NUMBER_WIDTH'(cand_q)),
		.rd_en   (rd_en),
		.rd_addr (AW'(idx_q)),
		.rd_data (rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job.valid) begin
					state_d = (limit_eff < VAL_W'(2)) ? ST_EMPTY : ST_TEST;
				end
			end
			ST_TEST: begin
				// Every stored prime has been tried without a zero remainder.
				state_d = (idx_q == cnt_q) ? ST_STORE : ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (last_step) begin
					state_d = rem_zero ? ST_NEXT : ST_TEST;
				end
			end
			ST_STORE: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_d = done ? ST_FLUSH : ST_TEST;
			end
			ST_FLUSH, ST_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output decode.
	always_comb begin
		job.ready  = state_q == ST_IDLE;
		start      = (state_q == ST_IDLE) && job.valid;
		rd_en      = (state_q == ST_TEST) && (idx_q != cnt_q);
		load_div   = state_q == ST_LOAD;
		div_step   = state_q == ST_DIV;
		idx_inc    = (state_q == ST_DIV) && last_step && !rem_zero;
		store      = (state_q == ST_STORE) && (!pend_valid_q || out_free);
		push_pend  = store && pend_valid_q;
		next_cand  = (state_q == ST_NEXT) && !done;
		push_final = (state_q == ST_FLUSH) && out_free;
		push_empty = (state_q == ST_EMPTY) && out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (store) begin
				cnt_q        <= cnt_q + 1'b1;
				pend_valid_q <= 1'b1;
			end else if (push_final) begin
				pend_valid_q <= 1'b0;
			end
			if (push_pend || push_final || push_empty) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			limit_q <= limit_eff;
			cand_q  <= VAL_W'(2);
			idx_q   <= '0;
		end else if (next_cand) begin
			cand_q <= cand_q + 1'b1;
			idx_q  <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end

		if (load_div) begin
			div_q  <= rd_data;
			rem_q  <= '0;
			dvd_q  <= cand_q;
			step_q <= '0;
		end else if (div_step) begin
			rem_q  <= rem_next;
			dvd_q  <= dvd_q << 1;
			step_q <= step_q + 1'b1;
		end

		if (store) begin
			pend_q <= cand_q;
		end

		if (push_pend) begin
			out_prime_q <= pend_q;
			out_last_q  <= 1'b0;
			out_none_q  <= 1'b0;
		end else if (push_final) begin
			out_prime_q <= pend_q;
			out_last_q  <= 1'b1;
			out_none_q  <= 1'b0;
		end else if (push_empty) begin
			out_prime_q <= '0;
			out_last_q  <= 1'b1;
			out_none_q  <= 1'b1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.prime      = out_prime_q;
	assign result.last       = out_last_q;
	assign result.none_found = out_none_q;

endmodule

// ===== rtl/core/pltd_checker.sv =====
module pltd_checker import pltd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             job_valid,
	input logic             job_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [VAL_W-1:0] res_prime,
	input logic             res_last,
	input logic             res_none
);

	logic             have_q;
	logic [VAL_W-1:0] prev_q;
	logic             res_take;

	assign res_take = res_valid && res_ready;

	// Remember the previous prime of the running request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			prev_q <= '0;
		end else if (res_take) begin
			have_q <= !res_last;
			prev_q <= res_prime;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> !job_ready)
		else $error("second request taken while a search runs");

	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_none |-> res_last && (res_prime == '0))
		else $error("empty result without last or with a prime");

	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_none |-> res_prime >= VAL_W'(2))
		else $error("prime below two");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && have_q |-> res_prime > prev_q)
		else $error("primes not ascending");

endmodule

bind prime_list_trial_division pltd_checker u_pltd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.job_valid (job.valid),
	.job_ready (job.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_prime (result.prime),
	.res_last  (result.last),
	.res_none  (result.none_found)
);

// ===== tb/sv/tb_prime_list_trial_division.sv =====
module tb_prime_list_trial_division import pltd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 64;
	localparam int NUMBER_WIDTH = 8;
	localparam int NUM_MASK     = (1 << NUMBER_WIDTH) - 1;

	// The slowest legal stretch without a handshake is the search across the widest gap
	// between primes below 256 at full table size, plus the longest ready stall. The limit
	// below sits far above that.
	localparam int STALL_LIMIT  = 200000;

	// Cycles allowed after the last expected result for any stray response to show up.
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [VAL_W-1:0] prime;
		logic             last;
		logic             none_found;
	} prime_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pltd_job_if    job_ch ();
	pltd_result_if result_ch ();

	prime_list_trial_division #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_ch),
		.result (result_ch)
	);

	// Requests still to be offered, and the results the predictor says must come back.
	logic [VAL_W-1:0] limit_queue [$];
	prime_result_t    primes_due [$];

	// The predictor's own copy of the prime table and its fill count.
	logic [NUMBER_WIDTH-1:0] found_primes [TABLE_DEPTH];
	int unsigned             found_count;

	bit            job_taken = 1'b0;
	int            job_gap;
	int            ready_hold;
	int            calm_left;
	int            idle_cycles;
	int            errors;
	prime_result_t want;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap lengths: mostly short, sometimes medium, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 90)
			return $urandom_range(4, 12);
		return $urandom_range(30, 300);
	endfunction

	// Work grows roughly with the square of the limit over log of it, so most random
	// requests stay small, a handful climb to mid range and only a few go to the top.
	function automatic logic [VAL_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return VAL_W'($urandom_range(0, 3));
		else if (r < 85)
			return VAL_W'($urandom_range(4, 48));
		else if (r < 96)
			return VAL_W'($urandom_range(49, 127));
		return VAL_W'($urandom_range(128, 255));
	endfunction

	// Expected responses for one request. The table is emptied for every request, each
	// candidate from two upward is divided by every prime stored so far in this request,
	// and the search also stops once the table or the result budget is used up.
	task automatic list_primes(input logic [VAL_W-1:0] lim);
		int unsigned   top;
		int unsigned   cand;
		bit            divisible;
		prime_result_t run [$];
		prime_result_t item;
		top = lim & NUM_MASK;
		found_count = 0;
		if (top < 2) begin
			item = '{prime: '0, last: 1'b1, none_found: 1'b1};
			primes_due.insert(primes_due.size(), item);
			return;
		end
		for (cand = 2; cand <= top; cand++) begin
			if (found_count >= TABLE_DEPTH || run.size() >= MAX_RESULTS)
				break;
			divisible = 1'b0;
			for (int i = 0; i < found_count; i++) begin
				if (found_primes[i] != 0 && (cand % found_primes[i]) == 0)
					divisible = 1'b1;
			end
			if (!divisible) begin
				found_primes[found_count] = NUMBER_WIDTH'(cand & NUM_MASK);
				found_count = (found_count + 1) & 7'h7F;
				item = '{prime: VAL_W'(cand), last: 1'b0, none_found: 1'b0};
				run.insert(run.size(), item);
			end
		end
		// The final prime of the request carries the last flag.
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[k])
			primes_due.insert(primes_due.size(), run[k]);
	endtask

	// Request driver. Everything changes on the falling edge so that the block sees stable
	// inputs at the rising edge. job_taken tells whether the request on the bus went in at
	// the edge just past; until then valid and limit are held.
	always @(negedge clk) begin
		if (!arst_n) begin
			job_ch.valid     <= 1'b0;
			job_ch.limit     <= '0;
			result_ch.ready  <= 1'b0;
		end else begin
			if (!job_ch.valid || job_taken) begin
				if (job_gap > 0) begin
					job_ch.valid <= 1'b0;
					job_gap--;
				end else if (limit_queue.size() > 0) begin
					job_ch.valid <= 1'b1;
					job_ch.limit <= limit_queue.pop_front();
					// About a third of the requests follow back to back.
					job_gap = ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
				end else begin
					job_ch.valid <= 1'b0;
				end
			end

			// Result back-pressure: random stalls of mixed length, broken up by calm
			// stretches in which ready stays high throughout.
			if (ready_hold > 0) begin
				result_ch.ready <= 1'b0;
				ready_hold--;
			end else begin
				result_ch.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 299) == 0)
					calm_left = $urandom_range(200, 3000);
				else if ($urandom_range(0, 9) == 0)
					ready_hold = pick_gap();
			end
		end
	end

	// Monitor. On the rising edge it notes accepted requests, feeds them to the predictor
	// and compares every accepted result with the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			job_taken <= job_ch.valid && job_ch.ready;
			if (job_ch.valid && job_ch.ready)
				list_primes(job_ch.limit);

			if (result_ch.valid && result_ch.ready) begin
				if (primes_due.size() == 0) begin
					$error("unexpected result: prime %0d last %0b none_found %0b",
						result_ch.prime, result_ch.last, result_ch.none_found);
					errors++;
				end else begin
					want = primes_due.pop_front();
					if (result_ch.prime !== want.prime) begin
						$error("prime: expected %0d, got %0d", want.prime, result_ch.prime);
						errors++;
					end
					if (result_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result_ch.last);
						errors++;
					end
					if (result_ch.none_found !== want.none_found) begin
						$error("none_found: expected %0b, got %0b",
							want.none_found, result_ch.none_found);
						errors++;
					end
				end
			end

			// Watchdog on handshake activity: a hung block never gets past this.
			if ((job_ch.valid && job_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		job_ch.valid    = 1'b0;
		job_ch.limit    = '0;
		result_ch.ready = 1'b0;
		job_gap     = 0;
		ready_hold  = 0;
		calm_left   = 0;
		idle_cycles = 0;
		errors      = 0;
		found_count = 0;

		// Directed requests: the two limits that yield nothing, the smallest lists, primes
		// and composites as limits, powers of two, the all-ones and alternating bit patterns
		// and the top of the range, where the table holds every prime the width allows.
		limit_queue.insert(limit_queue.size(), 8'd0);
		limit_queue.insert(limit_queue.size(), 8'd1);
		limit_queue.insert(limit_queue.size(), 8'd2);
		limit_queue.insert(limit_queue.size(), 8'd3);
		limit_queue.insert(limit_queue.size(), 8'd4);
		limit_queue.insert(limit_queue.size(), 8'd5);
		limit_queue.insert(limit_queue.size(), 8'd1);
		limit_queue.insert(limit_queue.size(), 8'd7);
		limit_queue.insert(limit_queue.size(), 8'd8);
		limit_queue.insert(limit_queue.size(), 8'd9);
		limit_queue.insert(limit_queue.size(), 8'd0);
		limit_queue.insert(limit_queue.size(), 8'd16);
		limit_queue.insert(limit_queue.size(), 8'd25);
		limit_queue.insert(limit_queue.size(), 8'h55);
		limit_queue.insert(limit_queue.size(), 8'd127);
		limit_queue.insert(limit_queue.size(), 8'd128);
		limit_queue.insert(limit_queue.size(), 8'hAA);
		limit_queue.insert(limit_queue.size(), 8'd254);
		limit_queue.insert(limit_queue.size(), 8'd255);
		limit_queue.insert(limit_queue.size(), 8'd2);

		repeat (80)
			limit_queue.insert(limit_queue.size(), pick_limit());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All requests in, then every expected result out, then a short drain.
		wait (limit_queue.size() == 0 && !job_ch.valid);
		wait (primes_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
